@@ hw/rtl/potr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// potr_pkg
// Shared types, codes and default sizes of the per-file ticket order tracker.
// ----------------------------------------------------------------------------
package potr_pkg;

    localparam int FILE_SLOTS_DEF  = 16;
    localparam int WINDOW_DEF      = 16;
    localparam int TICKET_BITS_DEF = 32;

    localparam int MODE_W    = 2;
    localparam int SLOT_IN_W = 4;
    localparam int PORT_W    = 32;
    localparam int STATUS_W  = 2;

    localparam logic [MODE_W-1:0] MODE_ACQ_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACQ_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_OUT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic load;
        logic eval;
        logic find;
        logic commit;
    } potr_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/potr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// potr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module potr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/potr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// potr_ctrl
// Sequencer that steps each request through read, evaluate, search and commit.
// ----------------------------------------------------------------------------
module potr_ctrl
    import potr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    output potr_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EVAL : S_IDLE;
            S_EVAL:  state_next = S_FIND;
            S_FIND:  state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign cmd.load   = start && (state_reg == S_IDLE);
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.find   = (state_reg == S_FIND);
    assign cmd.commit = (state_reg == S_DONE);

`ifndef SYNTH
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a request accepted three cycles earlier");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.eval, cmd.find, cmd.commit}))
        else $error("more than one datapath command at once");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start evaluation");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/potr_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// potr_datapath
// Slot state store, ticket checks, pending-bit search and result registers.
// ----------------------------------------------------------------------------
module potr_datapath
    import potr_pkg::*;
#(
    parameter int FILE_SLOTS  = FILE_SLOTS_DEF,
    parameter int WINDOW      = WINDOW_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire potr_cmd_t            cmd,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [SLOT_IN_W-1:0] file_slot,
    input  wire logic [PORT_W-1:0]    ticket,
    input  wire logic [PORT_W-1:0]    wait_level,
    output logic      [STATUS_W-1:0]  status,
    output logic      [PORT_W-1:0]    issued_ticket,
    output logic      [PORT_W-1:0]    wait_for,
    output logic                      granted,
    output logic      [PORT_W-1:0]    finished_level
);

    localparam int SW       = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int WB       = $clog2(WINDOW);
    localparam int TB       = TICKET_BITS;
    localparam int RW       = 3 * TB + WINDOW;
    localparam int LUT_SIZE = 1 << SLOT_IN_W;

    logic [SW-1:0]         slot_lut [LUT_SIZE];
    logic [SW-1:0]         slot_in;
    logic [FILE_SLOTS-1:0] valid_reg;
    logic                  valid_rd_reg;
    logic [RW-1:0]         rdata;
    logic [RW-1:0]         wdata;

    logic [MODE_W-1:0]     mode_reg;
    logic [SW-1:0]         slot_reg;
    logic [TB-1:0]         tk_reg;
    logic [TB-1:0]         wl_reg;

    logic [TB-1:0]         nt;
    logic [TB-1:0]         dl;
    logic [TB-1:0]         lw;
    logic [WINDOW-1:0]     pm;
    logic [TB-1:0]         gap;
    logic [TB-1:0]         off;
    logic                  exhausted;
    logic                  full;
    logic                  hit;

    logic [STATUS_W-1:0]   st_reg,     st_next;
    logic [TB-1:0]         issued_reg, issued_next;
    logic [TB-1:0]         waitf_reg,  waitf_next;
    logic                  grant_reg,  grant_next;
    logic [TB-1:0]         ntw_reg,    ntw_next;
    logic [TB-1:0]         lww_reg,    lww_next;
    logic [TB-1:0]         dl_reg;
    logic [WINDOW-1:0]     map_reg,    map_next;
    logic                  we_reg,     we_next;
    logic                  rel_reg,    rel_next;
    logic [WB-1:0]         j_reg,      j_next;
    logic                  zero_reg;

    logic [TB-1:0]         dl_new;
    logic [WINDOW-1:0]     map_new;

    for (genvar g = 0; g < LUT_SIZE; g++)
    begin : g_slot_lut
        assign slot_lut[g] = SW'(g % FILE_SLOTS);
    end

    assign slot_in = slot_lut[file_slot];

    potr_ram #(
        .WIDTH (RW),
        .DEPTH (FILE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.commit && we_reg),
        .waddr (slot_reg),
        .wdata (wdata),
        .re    (cmd.load),
        .raddr (slot_in),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit && we_reg)
        begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= mode;
            slot_reg     <= slot_in;
            tk_reg       <= TB'(ticket);
            wl_reg       <= TB'(wait_level);
            valid_rd_reg <= valid_reg[slot_in];
        end
    end

    assign nt = valid_rd_reg ? rdata[RW-1 -: TB]              : '0;
    assign dl = valid_rd_reg ? rdata[RW-TB-1 -: TB]           : '0;
    assign lw = valid_rd_reg ? rdata[WINDOW+TB-1 -: TB]       : '0;
    assign pm = valid_rd_reg ? rdata[WINDOW-1:0]              : '0;

    assign gap       = nt - dl;
    assign exhausted = &nt;
    assign full      = (gap >= TB'(WINDOW));
    assign off       = tk_reg - dl - TB'(1);
    assign hit       = (tk_reg > dl) && (off < TB'(WINDOW)) && pm[off[WB-1:0]];

    always_comb
    begin
        st_next     = ST_OK;
        issued_next = '0;
        waitf_next  = '0;
        grant_next  = 1'b0;
        ntw_next    = nt;
        lww_next    = lw;
        map_next    = pm;
        we_next     = 1'b0;
        rel_next    = 1'b0;
        case (mode_reg)
            MODE_ACQ_READ, MODE_ACQ_WRITE:
            begin
                if (exhausted)
                begin
                    st_next = ST_EXHAUSTED;
                end
                else if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    issued_next = nt + TB'(1);
                    ntw_next    = nt + TB'(1);
                    map_next    = pm | (WINDOW'(1) << gap[WB-1:0]);
                    we_next     = 1'b1;
                    if (mode_reg == MODE_ACQ_READ)
                    begin
                        waitf_next = lw;
                    end
                    else
                    begin
                        waitf_next = nt;
                        lww_next   = nt + TB'(1);
                    end
                    grant_next = (dl >= waitf_next);
                end
            end
            MODE_RELEASE:
            begin
                if (hit)
                begin
                    map_next = pm & ~(WINDOW'(1) << off[WB-1:0]);
                    we_next  = 1'b1;
                    rel_next = 1'b1;
                end
                else
                begin
                    st_next = ST_NOT_OUT;
                end
            end
            MODE_QUERY:
            begin
                grant_next = (dl >= wl_reg);
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            we_reg  <= 1'b0;
            rel_reg <= 1'b0;
        end
        else if (cmd.eval)
        begin
            we_reg  <= we_next;
            rel_reg <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            st_reg     <= st_next;
            issued_reg <= issued_next;
            waitf_reg  <= waitf_next;
            grant_reg  <= grant_next;
            ntw_reg    <= ntw_next;
            lww_reg    <= lww_next;
            dl_reg     <= dl;
            map_reg    <= map_next;
        end
        if (cmd.find)
        begin
            j_reg    <= j_next;
            zero_reg <= (map_reg == '0);
        end
    end

    always_comb
    begin
        j_next = '0;
        for (int i = WINDOW - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                j_next = WB'(i);
            end
        end
    end

    always_comb
    begin
        dl_new  = dl_reg;
        map_new = map_reg;
        if (rel_reg)
        begin
            if (zero_reg)
            begin
                dl_new  = ntw_reg;
                map_new = '0;
            end
            else
            begin
                dl_new  = dl_reg + TB'(j_reg);
                map_new = map_reg >> j_reg;
            end
        end
    end

    assign wdata = {ntw_reg, dl_new, lww_reg, map_new};

    assign status         = st_reg;
    assign issued_ticket  = PORT_W'(issued_reg);
    assign wait_for       = PORT_W'(waitf_reg);
    assign granted        = grant_reg;
    assign finished_level = PORT_W'(dl_new);

endmodule
`default_nettype wire

@@ hw/rtl/per_file_ticket_order_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_file_ticket_order_tracker
// Orders reads and writes per file slot with tickets and a pending window.
// ----------------------------------------------------------------------------
// The result strobe done is raised in the commit state, after the evaluate
// and search states. A new request is accepted only while idle, so each one
// passes read, evaluate, pending-bit search and commit on the slot-state RAM.
// The receiver cannot stall; the done strobe is high for exactly one cycle.
// Reset clears the sequencer and one valid bit per slot, so every slot reads
// as zero at once; there is no clearing pass.
module per_file_ticket_order_tracker
    import potr_pkg::*;
#(
    parameter int FILE_SLOTS  = FILE_SLOTS_DEF,
    parameter int WINDOW      = WINDOW_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [SLOT_IN_W-1:0] file_slot,
    input  wire logic [PORT_W-1:0]    ticket,
    input  wire logic [PORT_W-1:0]    wait_level,
    output logic                      done,
    output logic      [STATUS_W-1:0]  status,
    output logic      [PORT_W-1:0]    issued_ticket,
    output logic      [PORT_W-1:0]    wait_for,
    output logic                      granted,
    output logic      [PORT_W-1:0]    finished_level
);

    potr_cmd_t cmd;

    potr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    potr_datapath #(
        .FILE_SLOTS  (FILE_SLOTS),
        .WINDOW      (WINDOW),
        .TICKET_BITS (TICKET_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .file_slot      (file_slot),
        .ticket         (ticket),
        .wait_level     (wait_level),
        .status         (status),
        .issued_ticket  (issued_ticket),
        .wait_for       (wait_for),
        .granted        (granted),
        .finished_level (finished_level)
    );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-file ticket order tracker. A directed table
// covers the field extremes, every mode, out-of-order release, a full window
// and the refused releases. Random traffic follows, focused on a few slots so
// that windows fill and finished levels jump. A predictor in the bench works
// out each result, and every strobed result is checked field by field.
// ----------------------------------------------------------------------------
module testbench
    import potr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1050;
    localparam int CALM_TAIL       = 150;
    localparam int STALL_LIMIT     = 500;
    localparam int WIN_IDX_W       = $clog2(WINDOW_DEF);
    localparam logic [PORT_W-1:0] TICKET_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PORT_W-1:0]   issued;
        logic [PORT_W-1:0]   wait_for;
        logic                granted;
        logic [PORT_W-1:0]   finished;
    } tracker_result_t;

    typedef struct {
        logic [MODE_W-1:0]    op;
        logic [SLOT_IN_W-1:0] slot;
        logic [PORT_W-1:0]    tk;
        logic [PORT_W-1:0]    wl;
        int                   count;
        bit                   typed;
        tracker_result_t      want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_W-1:0]    mode;
    logic [SLOT_IN_W-1:0] file_slot;
    logic [PORT_W-1:0]    ticket;
    logic [PORT_W-1:0]    wait_level;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [PORT_W-1:0]    issued_ticket;
    logic [PORT_W-1:0]    wait_for;
    logic                 granted;
    logic [PORT_W-1:0]    finished_level;

    logic [PORT_W-1:0]     slot_newest     [FILE_SLOTS_DEF];
    logic [PORT_W-1:0]     slot_done       [FILE_SLOTS_DEF];
    logic [PORT_W-1:0]     slot_last_write [FILE_SLOTS_DEF];
    logic [WINDOW_DEF-1:0] slot_pending    [FILE_SLOTS_DEF];

    tracker_result_t expected_results[$];
    stim_row_t       directed_rows[$];
    int              mismatches = 0;
    int              stall_cycles = 0;

    per_file_ticket_order_tracker u_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic track_step(input logic [MODE_W-1:0] op, input logic [SLOT_IN_W-1:0] slot,
                              input logic [PORT_W-1:0] tk, input logic [PORT_W-1:0] wl,
                              output tracker_result_t res);
        logic [PORT_W-1:0]     newest;
        logic [PORT_W-1:0]     level;
        logic [PORT_W-1:0]     next_tk;
        logic [PORT_W-1:0]     offset;
        logic [WINDOW_DEF-1:0] rest;
        int                    lowest;
        res = '0;
        newest = slot_newest[slot];
        level = slot_done[slot];
        if (op == MODE_ACQ_READ || op == MODE_ACQ_WRITE)
        begin
            if (newest == TICKET_MAX)
            begin
                res.status = ST_EXHAUSTED;
            end
            else if (newest - level >= WINDOW_DEF)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                next_tk = newest + 1;
                offset = next_tk - level - 1;
                slot_pending[slot][offset[WIN_IDX_W-1:0]] = 1'b1;
                slot_newest[slot] = next_tk;
                if (op == MODE_ACQ_READ)
                begin
                    res.wait_for = slot_last_write[slot];
                end
                else
                begin
                    slot_last_write[slot] = next_tk;
                    res.wait_for = newest;
                end
                res.issued = next_tk;
                res.granted = (level >= res.wait_for);
            end
        end
        else if (op == MODE_RELEASE)
        begin
            offset = tk - level - 1;
            if (tk <= level || offset >= WINDOW_DEF ||
                !slot_pending[slot][offset[WIN_IDX_W-1:0]])
            begin
                res.status = ST_NOT_OUT;
            end
            else
            begin
                rest = slot_pending[slot];
                rest[offset[WIN_IDX_W-1:0]] = 1'b0;
                if (rest == '0)
                begin
                    slot_done[slot] = newest;
                    slot_pending[slot] = '0;
                end
                else
                begin
                    lowest = 0;
                    while (!rest[lowest])
                        lowest++;
                    slot_done[slot] = level + lowest;
                    slot_pending[slot] = rest >> lowest;
                end
            end
        end
        else
        begin
            res.granted = (level >= wl);
        end
        res.finished = slot_done[slot];
    endtask

    task automatic issue_request(input logic [MODE_W-1:0] op, input logic [SLOT_IN_W-1:0] slot,
                                 input logic [PORT_W-1:0] tk, input logic [PORT_W-1:0] wl,
                                 input bit typed, input tracker_result_t want);
        tracker_result_t predicted;
        tracker_result_t entry;
        mode <= op;
        file_slot <= slot;
        ticket <= tk;
        wait_level <= wl;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        track_step(op, slot, tk, wl, predicted);
        entry = typed ? want : predicted;
        expected_results = {expected_results, entry};
    endtask

    task automatic maybe_pause(input int index, input int total);
        if (index < total - CALM_TAIL && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [PORT_W-1:0] want,
                               input logic [PORT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result strobed with no request waiting, expected none, got %0h",
                         $time, status);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", PORT_W'(want.status), PORT_W'(status));
                check_field("issued_ticket", want.issued, issued_ticket);
                check_field("wait_for", want.wait_for, wait_for);
                check_field("granted", PORT_W'(want.granted), PORT_W'(granted));
                check_field("finished_level", want.finished, finished_level);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [MODE_W-1:0]    op;
        logic [SLOT_IN_W-1:0] slot;
        logic [PORT_W-1:0]    tk;
        logic [PORT_W-1:0]    wl;
        int                   pick;
        int                   bit_idx;
        int                   row_items;
        start = 1'b0;
        mode = MODE_QUERY;
        file_slot = '0;
        ticket = '0;
        wait_level = '0;
        rst_n = 1'b0;
        for (int s = 0; s < FILE_SLOTS_DEF; s++)
        begin
            slot_newest[s] = '0;
            slot_done[s] = '0;
            slot_last_write[s] = '0;
            slot_pending[s] = '0;
        end
        directed_rows = '{
            '{MODE_QUERY,     4'd0,  32'd0,         32'd0,         1,  1'b1,
              {ST_OK, 32'd0, 32'd0, 1'b1, 32'd0}},
            '{MODE_QUERY,     4'd15, TICKET_MAX,    TICKET_MAX,    1,  1'b1,
              {ST_OK, 32'd0, 32'd0, 1'b0, 32'd0}},
            '{MODE_RELEASE,   4'd3,  32'd0,         32'd0,         1,  1'b1,
              {ST_NOT_OUT, 32'd0, 32'd0, 1'b0, 32'd0}},
            '{MODE_RELEASE,   4'd3,  TICKET_MAX,    TICKET_MAX,    1,  1'b1,
              {ST_NOT_OUT, 32'd0, 32'd0, 1'b0, 32'd0}},
            '{MODE_ACQ_READ,  4'd5,  TICKET_MAX,    TICKET_MAX,    1,  1'b1,
              {ST_OK, 32'd1, 32'd0, 1'b1, 32'd0}},
            '{MODE_ACQ_WRITE, 4'd5,  32'd0,         32'd0,         1,  1'b1,
              {ST_OK, 32'd2, 32'd1, 1'b0, 32'd0}},
            '{MODE_ACQ_READ,  4'd5,  32'd0,         32'd0,         1,  1'b1,
              {ST_OK, 32'd3, 32'd2, 1'b0, 32'd0}},
            '{MODE_RELEASE,   4'd5,  32'd2,         32'd0,         1,  1'b0, '0},
            '{MODE_QUERY,     4'd5,  32'd0,         32'd1,         1,  1'b0, '0},
            '{MODE_RELEASE,   4'd5,  32'd1,         32'd0,         1,  1'b0, '0},
            '{MODE_QUERY,     4'd5,  32'd0,         32'd2,         1,  1'b0, '0},
            '{MODE_RELEASE,   4'd5,  32'd3,         32'd0,         1,  1'b0, '0},
            '{MODE_RELEASE,   4'd5,  32'd3,         32'd0,         1,  1'b1,
              {ST_NOT_OUT, 32'd0, 32'd0, 1'b0, 32'd3}},
            '{MODE_RELEASE,   4'd5,  32'd20,        32'd0,         1,  1'b1,
              {ST_NOT_OUT, 32'd0, 32'd0, 1'b0, 32'd3}},
            '{MODE_ACQ_WRITE, 4'd9,  32'h5555_5555, 32'hAAAA_AAAA, 16, 1'b0, '0},
            '{MODE_ACQ_READ,  4'd9,  32'd0,         32'd0,         1,  1'b1,
              {ST_FULL, 32'd0, 32'd0, 1'b0, 32'd0}},
            '{MODE_RELEASE,   4'd9,  32'd5,         32'd0,         1,  1'b0, '0},
            '{MODE_RELEASE,   4'd9,  32'd5,         32'd0,         1,  1'b1,
              {ST_NOT_OUT, 32'd0, 32'd0, 1'b0, 32'd0}},
            '{MODE_RELEASE,   4'd9,  32'd1,         32'd0,         1,  1'b0, '0},
            '{MODE_ACQ_WRITE, 4'd9,  32'd0,         32'd0,         1,  1'b0, '0},
            '{MODE_QUERY,     4'd9,  32'd0,         32'd0,         1,  1'b0, '0}
        };
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        row_items = 0;
        foreach (directed_rows[r])
        begin
            repeat (directed_rows[r].count)
            begin
                issue_request(directed_rows[r].op, directed_rows[r].slot, directed_rows[r].tk,
                              directed_rows[r].wl, directed_rows[r].typed,
                              directed_rows[r].want);
                maybe_pause(row_items, RANDOM_REQUESTS + CALM_TAIL);
                row_items++;
            end
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            slot = ($urandom_range(0, 9) < 7) ? SLOT_IN_W'($urandom_range(0, 3))
                                              : SLOT_IN_W'($urandom_range(0, 15));
            tk = $urandom();
            wl = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                op = MODE_ACQ_READ;
            end
            else if (pick < 40)
            begin
                op = MODE_ACQ_WRITE;
            end
            else if (pick < 75)
            begin
                op = MODE_RELEASE;
                pick = $urandom_range(0, 99);
                if (pick < 75 && slot_pending[slot] != '0)
                begin
                    bit_idx = $urandom_range(0, WINDOW_DEF - 1);
                    while (!slot_pending[slot][bit_idx])
                        bit_idx = $urandom_range(0, WINDOW_DEF - 1);
                    tk = slot_done[slot] + 1 + bit_idx;
                end
                else if (pick < 90)
                begin
                    tk = slot_done[slot] + $urandom_range(0, 20);
                end
            end
            else
            begin
                op = MODE_QUERY;
                if ($urandom_range(0, 1) == 1)
                    wl = slot_done[slot] + $urandom_range(0, 6) - 3;
            end
            issue_request(op, slot, tk, wl, 1'b0, '0);
            maybe_pause(n, RANDOM_REQUESTS);
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/potr_pkg.sv
hw/rtl/potr_ram.sv
hw/rtl/potr_ctrl.sv
hw/rtl/potr_datapath.sv
hw/rtl/per_file_ticket_order_tracker.sv
sim/testbench.sv
